// ===== rtl/bitonic_select_smallest_half_assert.svh =====
// Assertion macros for the checker file
`ifndef BITONIC_SELECT_SMALLEST_HALF_ASSERT_SVH
`define BITONIC_SELECT_SMALLEST_HALF_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define BSSH_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication checked in the cycle after the antecedent
`define BSSH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/bssh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssh_pkg
// Shared types for the bitonic smallest-half selector.
// ----------------------------------------------------------------------------
package bssh_pkg;
    localparam int TAG_BITS = 4;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_NET,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;   // write accepted pair into lanes
        logic init;   // first pairwise compare with fresh tags
        logic step;   // one network stage
    } cmd_t;
endpackage

// ===== rtl/bssh_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssh_dp
// Lane registers and one network stage applied per step.
// ----------------------------------------------------------------------------
module bssh_dp #(
    parameter int LIST_SIZE   = 8,
    parameter int LIST_LOG2   = 3,
    parameter int METRIC_BITS = 16,
    parameter int NSTAGE      = 1
) (
    input  logic                          aclk,
    input  bssh_pkg::cmd_t                cmd,
    input  logic [LIST_LOG2-1:0]          load_idx,
    input  logic [$clog2(NSTAGE+1)-1:0]   stage_idx,
    input  logic [LIST_LOG2-1:0]          emit_idx,
    input  logic [METRIC_BITS-1:0]        metric_even,
    input  logic [METRIC_BITS-1:0]        metric_odd,
    output logic [bssh_pkg::TAG_BITS-1:0] path_tag
);
    import bssh_pkg::*;

    localparam int SW = $clog2(NSTAGE + 1);
    localparam int LW = LIST_LOG2;

    logic [METRIC_BITS-1:0] hv_reg [LIST_SIZE];
    logic [METRIC_BITS-1:0] lv_reg [LIST_SIZE];
    logic [TAG_BITS-1:0]    ht_reg [LIST_SIZE];
    logic [TAG_BITS-1:0]    lt_reg [LIST_SIZE];

    // Stage schedule tables: kind (0 brown, 1 merge), layer/distance, first
    function automatic int stage_kind(int s);
        int n;
        n = 0;
        for (int l = 1; l < LIST_LOG2; l++) begin
            if (n == s) return 0;
            n++;
            for (int t = 1; t <= l; t++) begin
                if (n == s) return 1;
                n++;
            end
        end
        return 0;
    endfunction

    function automatic int stage_par(int s);
        int n;
        n = 0;
        for (int l = 1; l < LIST_LOG2; l++) begin
            if (n == s) return l;
            n++;
            for (int t = 1; t <= l; t++) begin
                if (n == s) return (1 << (l - t)) + ((t == 1) ? 64 : 0);
                n++;
            end
        end
        return LIST_LOG2;
    endfunction

    function automatic int fix(int i);
        return (i >= 0 && i < LIST_SIZE) ? i : 0;
    endfunction

    // Source selection per stage and lane: {a_hi, ia, b_hi, ib}
    function automatic int src(int s, int k, int which);
        int m, r, d, dd, p;
        logic ah, bh;
        int ia, ib;
        p = stage_par(s);
        if (stage_kind(s) == 0) begin
            m = 1 << p;
            ah = 1'b1;
            bh = 1'b0;
            if ((k & 1) == 0) begin
                r = k & (m - 1);
                ia = k - (r >> 1);
                ib = k + m - 1 - ((3 * r) >> 1);
            end else begin
                r = (k - 1) & (m - 1);
                ia = k + m - 2 - ((3 * r) >> 1);
                ib = k - (r >> 1) - 1;
            end
        end else begin
            d = p & 63;
            dd = d << 1;
            r = k & (dd - 1);
            if (r < d) begin
                ah = 1'b1; bh = 1'b1; ia = k; ib = k + d;
            end else if (p >= 64) begin
                ah = 1'b0; bh = 1'b0;
                ia = k + d - 1 - 2 * r + dd;
                ib = k - 1 - 2 * r + dd;
            end else begin
                ah = 1'b0; bh = 1'b0; ia = k - d; ib = k;
            end
        end
        case (which)
            0: return int'(ah);
            1: return fix(ia);
            2: return int'(bh);
            default: return fix(ib);
        endcase
    endfunction

    logic [METRIC_BITS-1:0] av [LIST_SIZE];
    logic [METRIC_BITS-1:0] bv [LIST_SIZE];
    logic [TAG_BITS-1:0]    at [LIST_SIZE];
    logic [TAG_BITS-1:0]    bt [LIST_SIZE];

    // Operand routing for the current stage
    always_comb begin
        for (int k = 0; k < LIST_SIZE; k++) begin
            av[k] = hv_reg[k];
            at[k] = TAG_BITS'(2 * k);
            bv[k] = lv_reg[k];
            bt[k] = TAG_BITS'(2 * k + 1);
            if (!cmd.init) begin
                for (int s = 0; s < NSTAGE; s++) begin
                    if (stage_idx == SW'(s)) begin
                        if (src(s, k, 0) != 0) begin
                            av[k] = hv_reg[LW'(src(s, k, 1))];
                            at[k] = ht_reg[LW'(src(s, k, 1))];
                        end else begin
                            av[k] = lv_reg[LW'(src(s, k, 1))];
                            at[k] = lt_reg[LW'(src(s, k, 1))];
                        end
                        if (src(s, k, 2) != 0) begin
                            bv[k] = hv_reg[LW'(src(s, k, 3))];
                            bt[k] = ht_reg[LW'(src(s, k, 3))];
                        end else begin
                            bv[k] = lv_reg[LW'(src(s, k, 3))];
                            bt[k] = lt_reg[LW'(src(s, k, 3))];
                        end
                    end
                end
            end
        end
    end

    // Lane registers: load, or compare-exchange
    always_ff @(posedge aclk) begin
        for (int k = 0; k < LIST_SIZE; k++) begin
            if (cmd.load && load_idx == LW'(k)) begin
                hv_reg[k] <= metric_even;
                lv_reg[k] <= metric_odd;
            end else if (cmd.init || cmd.step) begin
                if (av[k] >= bv[k]) begin
                    hv_reg[k] <= av[k]; ht_reg[k] <= at[k];
                    lv_reg[k] <= bv[k]; lt_reg[k] <= bt[k];
                end else begin
                    hv_reg[k] <= bv[k]; ht_reg[k] <= bt[k];
                    lv_reg[k] <= av[k]; lt_reg[k] <= at[k];
                end
            end
        end
    end

    assign path_tag = lt_reg[emit_idx];
endmodule

// ===== rtl/bssh_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssh_ctrl
// Sequencer: load pairs, run network stages, emit tags.
// ----------------------------------------------------------------------------
module bssh_ctrl #(
    parameter int LIST_SIZE = 8,
    parameter int LIST_LOG2 = 3,
    parameter int NSTAGE    = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_last,
    output bssh_pkg::cmd_t              cmd,
    output logic [LIST_LOG2-1:0]        load_idx,
    output logic [$clog2(NSTAGE+1)-1:0] stage_idx,
    output logic [LIST_LOG2-1:0]        emit_idx
);
    import bssh_pkg::*;

    localparam int SW = $clog2(NSTAGE + 1);

    state_t               state_reg, state_next;
    logic [LIST_LOG2-1:0] cnt_reg, cnt_next;
    logic [SW-1:0]        stg_reg, stg_next;
    logic                 ini_reg, ini_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        stg_next   = stg_reg;
        ini_next   = ini_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_valid) begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LIST_LOG2'(LIST_SIZE - 1)) begin
                        state_next = ST_NET;
                        ini_next   = 1'b1;
                        stg_next   = '0;
                    end
                end
            end
            ST_NET: begin
                if (ini_reg) begin
                    ini_next = 1'b0;
                end else if (stg_reg == SW'(NSTAGE - 1)) begin
                    state_next = ST_EMIT;
                    cnt_next   = '0;
                end else begin
                    stg_next = stg_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_ready) begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LIST_LOG2'(LIST_SIZE - 1)) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Outputs
    always_comb begin
        in_ready  = (state_reg == ST_LOAD);
        out_valid = (state_reg == ST_EMIT);
        out_last  = (cnt_reg == LIST_LOG2'(LIST_SIZE - 1));
        cmd.load  = (state_reg == ST_LOAD) && in_valid;
        cmd.init  = (state_reg == ST_NET) && ini_reg;
        cmd.step  = (state_reg == ST_NET) && !ini_reg;
        load_idx  = cnt_reg;
        stage_idx = stg_reg;
        emit_idx  = cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            stg_reg   <= '0;
            ini_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            stg_reg   <= stg_next;
            ini_reg   <= ini_next;
        end
    end
endmodule

// ===== rtl/bitonic_select_smallest_half.sv =====
`timescale 1ns / 1ps
// Sequencing: after the last pair is accepted, the init compare and then the network steps run
//   before the first tag is valid; no new pairs are taken during the network steps or the emit
//   phase, since the single shared compare-exchange stage is reused for every network stage.
// Reset: synchronous active-low aresetn clears the sequencer; lane data is not reset.
// ----------------------------------------------------------------------------
// bitonic_select_smallest_half
// Collects pairs of metrics, sorts through a bitonic network, emits smallest-half tags.
// ----------------------------------------------------------------------------
module bitonic_select_smallest_half #(
    parameter int LIST_SIZE   = 8,
    parameter int LIST_LOG2   = 3,
    parameter int METRIC_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [2*METRIC_BITS-1:0]   s_tdata,   // metric_even, metric_odd
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // path_tag, zero pad
    output logic                       m_tlast    // last_tag
);
    import bssh_pkg::*;

    localparam int NSTAGE = LIST_LOG2 + (LIST_LOG2 - 1) * LIST_LOG2 / 2;
    localparam int SW = $clog2(NSTAGE + 1);

    cmd_t                 cmd;
    logic [LIST_LOG2-1:0] load_idx, emit_idx;
    logic [SW-1:0]        stage_idx;
    logic [TAG_BITS-1:0]  path_tag;

    bssh_ctrl #(.LIST_SIZE(LIST_SIZE), .LIST_LOG2(LIST_LOG2), .NSTAGE(NSTAGE)) u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_last(m_tlast),
        .cmd, .load_idx, .stage_idx, .emit_idx
    );

    bssh_dp #(.LIST_SIZE(LIST_SIZE), .LIST_LOG2(LIST_LOG2),
              .METRIC_BITS(METRIC_BITS), .NSTAGE(NSTAGE)) u_dp (
        .aclk, .cmd, .load_idx, .stage_idx, .emit_idx,
        .metric_even(s_tdata[METRIC_BITS-1:0]),
        .metric_odd(s_tdata[2*METRIC_BITS-1:METRIC_BITS]),
        .path_tag
    );

    assign m_tdata = {4'b0, path_tag};
endmodule

// ===== rtl/bssh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssh_checker
// Port-level checks for the smallest-half selector.
// ----------------------------------------------------------------------------
`include "bitonic_select_smallest_half_assert.svh"
module bssh_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    // never takes input while emitting
    `BSSH_ASSERT_IMPL(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready)
    // held result stays put
    `BSSH_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // after last item, back to load
    `BSSH_ASSERT_NEXT(a_last_end, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid)
    // pad bits are zero
    `BSSH_ASSERT_IMPL(a_pad, aclk, aresetn, m_tvalid, m_tdata[7:4] == 4'b0)
endmodule

bind bitonic_select_smallest_half bssh_checker u_bssh_checker (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);
